/* sv/ptm_pkg.sv */
// shared types and constants for the page table mapper
// used by ptm_ctrl, ptm_datapath and page_table_mapper; no dependencies
`default_nettype none

package ptm_pkg;

    localparam int DEF_MEM_BYTES   = 64;
    localparam int DEF_FRAME_BYTES = 16;

    localparam int         IN_W       = 24;
    localparam int         OUT_W      = 16;
    localparam logic [7:0] EMPTY_MARK = 8'hFF;
    localparam int         VPN_LSB    = 4;
    localparam int         FIRST_VPN  = 2;
    localparam int         ENTRY_STEP = 3;

    typedef enum logic [1:0] {
        ST_MAPPED  = 2'd0,
        ST_ALREADY = 2'd1,
        ST_NOFREE  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic clr_wr;
        logic load_in;
        logic f_clear;
        logic f_inc;
        logic rd_hdr;
        logic set_table;
        logic new_table;
        logic set_data;
        logic rd_entry;
        logic rd_rw;
        logic off_inc;
        logic wr_bits;
        logic wr_vpn;
        logic wr_pfn;
        logic take_rw;
        logic free_data;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hdr_match;
        logic frame_free;
        logic f_last;
        logic vpn_match;
        logic entry_empty;
        logic more_entries;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* sv/page_table_mapper.sv */
// page table mapper top level: joins ptm_ctrl and ptm_datapath
// depends on ptm_pkg, ptm_ctrl, ptm_datapath
`default_nettype none

// Maps one virtual page per request into a small physical memory of
// MEM_BYTES bytes cut into MEM_BYTES / FRAME_BYTES frames, each process
// owning one page-table frame found by its id in the frame's first byte.
// Requests are handled one at a time. A request runs a header search (one
// memory read and one compare per frame, single read port), then the table
// and data free-frame scans, a read and a compare per table entry scanned,
// then the entry write or the rw read, and last loads the result and goes
// back to idle for the next beat; it takes longer while the previous result
// beat still waits for i_m_tready. After reset the block clears the memory
// to the empty marker, one byte a cycle, and takes no request during that
// pass.
module page_table_mapper #(
    parameter int MEM_BYTES   = ptm_pkg::DEF_MEM_BYTES,
    parameter int FRAME_BYTES = ptm_pkg::DEF_FRAME_BYTES
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    // pid[7:0], vaddr[13:8], entry_bits[21:14], zero fill
    input  wire logic [ptm_pkg::IN_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // status[1:0], table_created[2], table_frame[4:3], data_frame[6:5],
    // page_number[8:7], existing_rw[9], zero fill
    output logic [ptm_pkg::OUT_W-1:0]      o_m_tdata
);

    ptm_pkg::t_cmd  cmd;
    ptm_pkg::t_stat stat;

    ptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptm_datapath #(
        .MEM_BYTES   (MEM_BYTES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

/* sv/ptm_datapath.sv */
// datapath: physical memory, frame used flags, request and result registers
// depends on ptm_pkg; driven by ptm_ctrl commands
`default_nettype none

module ptm_datapath #(
    parameter int MEM_BYTES   = ptm_pkg::DEF_MEM_BYTES,
    parameter int FRAME_BYTES = ptm_pkg::DEF_FRAME_BYTES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire ptm_pkg::t_cmd           i_cmd,
    output ptm_pkg::t_stat               o_stat,
    input  wire logic [ptm_pkg::IN_W-1:0] i_s_tdata,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [ptm_pkg::OUT_W-1:0]    o_m_tdata
);

    localparam int NUM_FRAMES = MEM_BYTES / FRAME_BYTES;
    localparam int AW = $clog2(MEM_BYTES);
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int OW = $clog2(FRAME_BYTES + 4);

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;

    logic [NUM_FRAMES-1:0] r_used;
    logic [AW-1:0]         r_clr;
    logic [FW-1:0]         r_f;
    logic [FW-1:0]         r_table;
    logic [FW-1:0]         r_data;
    logic [OW-1:0]         r_off;

    logic [7:0] r_pid;
    logic [1:0] r_vpn;
    logic [7:0] r_bits;

    ptm_pkg::t_status r_status;
    logic             r_created;
    logic [1:0]       r_tframe;
    logic [1:0]       r_dframe;
    logic             r_rw;

    logic             r_ovalid;
    logic [ptm_pkg::OUT_W-1:0] r_odata;

    logic [AW-1:0] base_f;
    logic [AW-1:0] base_t;
    logic [AW-1:0] e_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;
    logic [OW:0]   off_next_end;

    assign base_f = AW'(r_f) * AW'(FRAME_BYTES);
    assign base_t = AW'(r_table) * AW'(FRAME_BYTES);
    assign e_addr = base_t + AW'(r_off);

    always_comb begin
        if (i_cmd.rd_hdr) begin
            rd_addr = base_f;
        end else if (i_cmd.rd_rw) begin
            rd_addr = e_addr - AW'(1);
        end else begin
            rd_addr = e_addr;
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = e_addr;
        wr_data = r_pid;
        if (i_cmd.clr_wr) begin
            wr_addr = r_clr;
            wr_data = ptm_pkg::EMPTY_MARK;
        end else if (i_cmd.new_table) begin
            wr_addr = base_f;
            wr_data = r_pid;
        end else if (i_cmd.wr_bits) begin
            wr_addr = e_addr - AW'(1);
            wr_data = r_bits;
        end else if (i_cmd.wr_vpn) begin
            wr_addr = e_addr;
            wr_data = {6'd0, r_vpn};
        end else if (i_cmd.wr_pfn) begin
            wr_addr = e_addr + AW'(1);
            wr_data = 8'(r_data);
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign off_next_end = {1'b0, r_off} + (OW+1)'(4);

    assign o_stat.clr_last     = (r_clr == AW'(MEM_BYTES - 1));
    assign o_stat.hdr_match    = (r_rdata == r_pid);
    assign o_stat.frame_free   = !r_used[r_f];
    assign o_stat.f_last       = (r_f == FW'(NUM_FRAMES - 1));
    assign o_stat.vpn_match    = (r_rdata == {6'd0, r_vpn});
    assign o_stat.entry_empty  = (r_rdata == ptm_pkg::EMPTY_MARK);
    assign o_stat.more_entries = (off_next_end < (OW+1)'(FRAME_BYTES));
    assign o_stat.out_free     = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.new_table) begin
                r_used[r_f] <= 1'b1;
            end else if (i_cmd.set_data) begin
                r_used[r_f] <= 1'b1;
            end else if (i_cmd.free_data) begin
                r_used[r_data] <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pid     <= i_s_tdata[7:0];
            r_vpn     <= i_s_tdata[8+ptm_pkg::VPN_LSB +: 2];
            r_bits    <= i_s_tdata[21:14];
            r_status  <= ptm_pkg::ST_NOFREE;
            r_created <= 1'b0;
            r_tframe  <= 2'd0;
            r_dframe  <= 2'd0;
            r_rw      <= 1'b0;
        end
        if (i_cmd.f_clear) begin
            r_f <= '0;
        end else if (i_cmd.f_inc) begin
            r_f <= r_f + FW'(1);
        end
        if (i_cmd.set_table || i_cmd.new_table) begin
            r_table  <= r_f;
            r_tframe <= 2'(r_f);
        end
        if (i_cmd.new_table) begin
            r_created <= 1'b1;
        end
        if (i_cmd.set_data) begin
            r_data   <= r_f;
            r_off    <= OW'(ptm_pkg::FIRST_VPN);
            r_status <= ptm_pkg::ST_FULL;
        end
        if (i_cmd.off_inc) begin
            r_off <= r_off + OW'(ptm_pkg::ENTRY_STEP);
        end
        if (i_cmd.take_rw) begin
            r_rw     <= r_rdata[0];
            r_status <= ptm_pkg::ST_ALREADY;
        end
        if (i_cmd.wr_pfn) begin
            r_dframe <= 2'(r_data);
            r_status <= ptm_pkg::ST_MAPPED;
        end
        if (i_cmd.load_out) begin
            r_odata <= {6'd0, r_rw, r_vpn, r_dframe, r_tframe, r_created, r_status};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_ovalid || i_m_tready))
        else $error("result loaded over a beat not yet taken");

    a_free_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.free_data |=> !r_used[r_data])
        else $error("released data frame still marked used");

    a_data_from_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_data |-> !r_used[r_f])
        else $error("data frame taken from a used frame");

endmodule

`default_nettype wire

/* sv/ptm_ctrl.sv */
// controller state machine for the page table mapper
// depends on ptm_pkg; issues commands to ptm_datapath
`default_nettype none

module ptm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire ptm_pkg::t_stat i_stat,
    output ptm_pkg::t_cmd       o_cmd
);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_HDR_RD = 13'b0000000000100,
        S_HDR_CK = 13'b0000000001000,
        S_TSCAN  = 13'b0000000010000,
        S_DSCAN  = 13'b0000000100000,
        S_ERD    = 13'b0000001000000,
        S_ECK    = 13'b0000010000000,
        S_RW_RD  = 13'b0000100000000,
        S_RW_CK  = 13'b0001000000000,
        S_W_VPN  = 13'b0010000000000,
        S_W_PFN  = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.f_clear = 1'b1;
                    n_state       = S_HDR_RD;
                end
            end
            S_HDR_RD: begin
                o_cmd.rd_hdr = 1'b1;
                n_state      = S_HDR_CK;
            end
            S_HDR_CK: begin
                if (i_stat.hdr_match) begin
                    o_cmd.set_table = 1'b1;
                    o_cmd.f_clear   = 1'b1;
                    n_state         = S_DSCAN;
                end else if (i_stat.f_last) begin
                    o_cmd.f_clear = 1'b1;
                    n_state       = S_TSCAN;
                end else begin
                    o_cmd.f_inc = 1'b1;
                    n_state     = S_HDR_RD;
                end
            end
            S_TSCAN: begin
                if (i_stat.frame_free) begin
                    o_cmd.new_table = 1'b1;
                    o_cmd.f_clear   = 1'b1;
                    n_state         = S_DSCAN;
                end else if (i_stat.f_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.f_inc = 1'b1;
                end
            end
            S_DSCAN: begin
                if (i_stat.frame_free) begin
                    o_cmd.set_data = 1'b1;
                    n_state        = S_ERD;
                end else if (i_stat.f_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.f_inc = 1'b1;
                end
            end
            S_ERD: begin
                o_cmd.rd_entry = 1'b1;
                n_state        = S_ECK;
            end
            S_ECK: begin
                if (i_stat.vpn_match) begin
                    n_state = S_RW_RD;
                end else if (i_stat.entry_empty) begin
                    o_cmd.wr_bits = 1'b1;
                    n_state       = S_W_VPN;
                end else if (i_stat.more_entries) begin
                    o_cmd.off_inc = 1'b1;
                    n_state       = S_ERD;
                end else begin
                    o_cmd.free_data = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_RW_RD: begin
                o_cmd.rd_rw = 1'b1;
                n_state     = S_RW_CK;
            end
            S_RW_CK: begin
                o_cmd.take_rw   = 1'b1;
                o_cmd.free_data = 1'b1;
                n_state         = S_FIN;
            end
            S_W_VPN: begin
                o_cmd.wr_vpn = 1'b1;
                n_state      = S_W_PFN;
            end
            S_W_PFN: begin
                o_cmd.wr_pfn = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
